FILE: rtl/header_field_value_extractor_core_defines.svh
// assertion macros for the header field value extractor
// no dependencies; included by the top level only
`ifndef HEADER_FIELD_VALUE_EXTRACTOR_CORE_DEFINES_SVH
`define HEADER_FIELD_VALUE_EXTRACTOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HFVE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define HFVE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define HFVE_ASSERT(lbl, prop, msg)
`define HFVE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/hfve_pkg.sv
// types, constants and helper functions for the header field value extractor
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package hfve_pkg;

    localparam int KEY_MAX_DEF   = 16;
    localparam int VALUE_MAX_DEF = 256;
    localparam int KEY_CHARS     = 16;
    localparam int KLEN_W        = 5;
    localparam int LIMIT_W       = 9;
    localparam int OQ_DEPTH      = 4;
    localparam int OQ_PTR_W      = 2;
    localparam int OQ_LVL_W      = 3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [KLEN_W-1:0]  KEY_LEN_RST   = 5'd1;
    localparam logic [LIMIT_W-1:0] VAL_LIMIT_RST = 9'd256;

    typedef enum logic [1:0] {
        CFG_KEY_LO  = 2'd0,
        CFG_KEY_HI  = 2'd1,
        CFG_KEY_LEN = 2'd2,
        CFG_VAL_LIM = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_SKIP   = 2'd1,
        PH_COPY   = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       is_final;
        logic       found;
    } t_result;

    typedef struct packed {
        logic       shift;
        logic       clear;
        logic [7:0] text_byte;
    } t_win_ctrl;

    typedef struct packed {
        logic                room2;
        logic [OQ_LVL_W-1:0] level;
    } t_fifo_stat;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

FILE: rtl/hfve_matcher.sv
// case-folded sliding window and parallel key compare
// depends on hfve_pkg
`timescale 1ns / 1ps

module hfve_matcher #(
    parameter int KEY_MAX = hfve_pkg::KEY_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hfve_pkg::t_win_ctrl        i_ctrl,
    input  logic [63:0]                i_key_lo,
    input  logic [63:0]                i_key_hi,
    input  logic [hfve_pkg::KLEN_W-1:0] i_key_len,
    output logic                       o_match
);

    localparam logic [hfve_pkg::KLEN_W-1:0] KLEN_MAX = hfve_pkg::KLEN_W'(KEY_MAX);

    logic [7:0]                  r_win [KEY_MAX];
    logic [7:0]                  n_win [KEY_MAX];
    logic [hfve_pkg::KLEN_W-1:0] r_fill;
    logic [hfve_pkg::KLEN_W-1:0] n_fill;
    logic [hfve_pkg::KLEN_W-1:0] k_eff;
    logic [7:0]                  key_ch [hfve_pkg::KEY_CHARS];
    logic [KEY_MAX-1:0]          pos_ok;
    logic [5:0]                  pos_sum [KEY_MAX];
    logic [3:0]                  pos_idx [KEY_MAX];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            key_ch[i]     = hfve_pkg::fold(i_key_lo[8*i +: 8]);
            key_ch[i + 8] = hfve_pkg::fold(i_key_hi[8*i +: 8]);
        end
    end

    always_comb begin
        if (i_key_len == '0) begin
            k_eff = hfve_pkg::KLEN_W'(1);
        end else if (i_key_len > KLEN_MAX) begin
            k_eff = KLEN_MAX;
        end else begin
            k_eff = i_key_len;
        end
    end

    // shifted window, newest byte at the top
    always_comb begin
        for (int j = 0; j < KEY_MAX - 1; j++) begin
            n_win[j] = r_win[j + 1];
        end
        n_win[KEY_MAX-1] = hfve_pkg::fold(i_ctrl.text_byte);
        n_fill = (r_fill == KLEN_MAX) ? r_fill : r_fill + 1'b1;
    end

    always_comb begin
        for (int j = 0; j < KEY_MAX; j++) begin
            pos_sum[j] = 6'(j) + 6'(k_eff);
            pos_idx[j] = 4'(pos_sum[j] - 6'(KEY_MAX));
            pos_ok[j]  = (pos_sum[j] < 6'(KEY_MAX)) || (n_win[j] == key_ch[pos_idx[j]]);
        end
        o_match = (&pos_ok) && (n_fill >= k_eff);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_fill <= '0;
        end else if (i_ctrl.shift) begin
            r_fill <= n_fill;
        end
    end

endmodule

FILE: rtl/hfve_out_fifo.sv
// four-entry result queue taking up to two results per cycle
// depends on hfve_pkg
`timescale 1ns / 1ps

module hfve_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push0,
    input  logic                 i_push1,
    input  hfve_pkg::t_result    i_res0,
    input  hfve_pkg::t_result    i_res1,
    output hfve_pkg::t_fifo_stat o_stat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hfve_pkg::t_result    o_res
);

    hfve_pkg::t_result                r_mem [hfve_pkg::OQ_DEPTH];
    logic [hfve_pkg::OQ_PTR_W-1:0]    r_wr_ptr;
    logic [hfve_pkg::OQ_PTR_W-1:0]    r_rd_ptr;
    logic [hfve_pkg::OQ_LVL_W-1:0]    r_level;
    logic [hfve_pkg::OQ_LVL_W-1:0]    n_level;
    logic [hfve_pkg::OQ_PTR_W-1:0]    wr_ptr1;
    logic                             pop;
    logic [1:0]                       n_push;

    assign pop     = o_valid && i_ready;
    assign wr_ptr1 = r_wr_ptr + 1'b1;
    assign n_push  = {1'b0, i_push0} + {1'b0, i_push1};
    assign n_level = r_level + hfve_pkg::OQ_LVL_W'(n_push) - hfve_pkg::OQ_LVL_W'(pop);

    assign o_valid      = (r_level != '0);
    assign o_res        = r_mem[r_rd_ptr];
    assign o_stat.room2 = (r_level <= hfve_pkg::OQ_LVL_W'(hfve_pkg::OQ_DEPTH - 2));
    assign o_stat.level = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push1) begin
            r_mem[wr_ptr1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + hfve_pkg::OQ_PTR_W'(n_push);
            r_rd_ptr <= r_rd_ptr + hfve_pkg::OQ_PTR_W'(pop);
            r_level  <= n_level;
        end
    end

endmodule

FILE: rtl/header_field_value_extractor_core.sv
// header field value extractor: searches a header byte stream for a key and
// emits the value bytes after it, closed by one status result per run.
// channels: input bytes (i_in_valid / o_in_ready, i_text_byte, i_end_of_text),
// results (o_out_valid / i_out_ready, o_value_byte, o_is_final, o_found) and a
// register write channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data).
// each input transfer lands in an input register and is processed by the phase
// machine and window compare once the queue has room for two results; its zero,
// one or two results enter a four-entry result queue. throughput is one byte per
// cycle while the receiver keeps up; the input register only advances when the
// queue has room for two results, so a stalled receiver stops intake after the
// queue fills, without loss. the terminator clears the run state so the next
// byte starts a new run. reset empties the queue and the input register, clears
// the run state and loads the register defaults (key zero, key length 1, value
// limit 256). configuration writes are always accepted.
// depends on hfve_pkg, hfve_matcher, hfve_out_fifo and the defines header
`timescale 1ns / 1ps
`include "header_field_value_extractor_core_defines.svh"

module header_field_value_extractor_core #(
    parameter int KEY_MAX   = hfve_pkg::KEY_MAX_DEF,
    parameter int VALUE_MAX = hfve_pkg::VALUE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_value_byte,
    output logic        o_is_final,
    output logic        o_found,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int VAL_CAP_I = (VALUE_MAX > 511) ? 511 : VALUE_MAX;
    localparam int CNT_W     = $clog2(VAL_CAP_I);
    localparam logic [hfve_pkg::LIMIT_W-1:0] VAL_CAP = hfve_pkg::LIMIT_W'(VAL_CAP_I);

    logic [63:0]                  r_key_lo;
    logic [63:0]                  r_key_hi;
    logic [hfve_pkg::KLEN_W-1:0]  r_key_len;
    logic [hfve_pkg::LIMIT_W-1:0] r_val_lim;

    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_in_end;

    hfve_pkg::t_phase             r_phase;
    hfve_pkg::t_phase             n_phase;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;

    hfve_pkg::t_win_ctrl          win_ctrl;
    hfve_pkg::t_fifo_stat         fifo_stat;
    hfve_pkg::t_result            res0;
    hfve_pkg::t_result            res1;
    hfve_pkg::t_result            out_res;
    logic                         push0;
    logic                         push1;
    logic                         match;
    logic                         go;
    logic                         in_take;

    logic                         ends;
    logic                         crlf;
    logic                         blank;
    logic [hfve_pkg::LIMIT_W-1:0] lim_eff;
    logic [hfve_pkg::LIMIT_W-1:0] cap;
    logic [hfve_pkg::LIMIT_W-1:0] cnt_ext;
    logic [hfve_pkg::LIMIT_W-1:0] cnt_inc;
    logic                         cap_zero;
    logic                         cnt_full;
    logic                         inc_full;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo  <= '0;
            r_key_hi  <= '0;
            r_key_len <= hfve_pkg::KEY_LEN_RST;
            r_val_lim <= hfve_pkg::VAL_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (hfve_pkg::t_cfg_idx'(i_cfg_index))
                hfve_pkg::CFG_KEY_LO:  r_key_lo  <= i_cfg_data;
                hfve_pkg::CFG_KEY_HI:  r_key_hi  <= i_cfg_data;
                hfve_pkg::CFG_KEY_LEN: r_key_len <= i_cfg_data[hfve_pkg::KLEN_W-1:0];
                hfve_pkg::CFG_VAL_LIM: r_val_lim <= i_cfg_data[hfve_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    assign go         = r_in_valid && fifo_stat.room2;
    assign o_in_ready = !r_in_valid || go;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_text_byte;
            r_in_end  <= i_end_of_text;
        end
    end

    // byte classes and capture limit
    assign ends  = r_in_end || (r_in_byte == hfve_pkg::CH_NUL);
    assign crlf  = (r_in_byte == hfve_pkg::CH_CR) || (r_in_byte == hfve_pkg::CH_LF);
    assign blank = (r_in_byte == hfve_pkg::CH_SPACE) || (r_in_byte == hfve_pkg::CH_TAB);

    assign lim_eff  = (r_val_lim > VAL_CAP) ? VAL_CAP : r_val_lim;
    assign cap      = (lim_eff == '0) ? '0 : lim_eff - 1'b1;
    assign cnt_ext  = hfve_pkg::LIMIT_W'(r_count);
    assign cnt_inc  = cnt_ext + 1'b1;
    assign cap_zero = (cap == '0);
    assign cnt_full = (cnt_ext >= cap);
    assign inc_full = (cnt_inc >= cap);

    // phase machine: next state
    always_comb begin
        n_phase = r_phase;
        if (go) begin
            case (r_phase)
                hfve_pkg::PH_SEARCH: begin
                    if (ends) begin
                        n_phase = hfve_pkg::PH_DONE;
                    end else if (match) begin
                        n_phase = hfve_pkg::PH_SKIP;
                    end
                end
                hfve_pkg::PH_SKIP: begin
                    if (!ends && blank) begin
                        n_phase = hfve_pkg::PH_SKIP;
                    end else if (ends || crlf || cap_zero || inc_full) begin
                        n_phase = hfve_pkg::PH_DONE;
                    end else begin
                        n_phase = hfve_pkg::PH_COPY;
                    end
                end
                hfve_pkg::PH_COPY: begin
                    if (ends || crlf || cnt_full || inc_full) begin
                        n_phase = hfve_pkg::PH_DONE;
                    end
                end
                default: n_phase = r_phase;
            endcase
            if (r_in_end) begin
                n_phase = hfve_pkg::PH_SEARCH;
            end
        end
    end

    // phase machine: outputs
    always_comb begin
        push0              = 1'b0;
        push1              = 1'b0;
        res0.value_byte    = '0;
        res0.is_final      = 1'b1;
        res0.found         = 1'b0;
        res1.value_byte    = '0;
        res1.is_final      = 1'b1;
        res1.found         = 1'b1;
        n_count            = r_count;
        win_ctrl.shift     = 1'b0;
        win_ctrl.clear     = 1'b0;
        win_ctrl.text_byte = r_in_byte;
        if (go) begin
            case (r_phase)
                hfve_pkg::PH_SEARCH: begin
                    if (ends) begin
                        push0 = 1'b1;
                    end else begin
                        win_ctrl.shift = 1'b1;
                    end
                end
                hfve_pkg::PH_SKIP: begin
                    if (!ends && blank) begin
                        push0 = 1'b0;
                    end else if (ends || crlf || cap_zero) begin
                        push0 = 1'b1;
                    end else begin
                        push0           = 1'b1;
                        res0.value_byte = r_in_byte;
                        res0.is_final   = 1'b0;
                        n_count         = CNT_W'(cnt_inc);
                        push1           = inc_full;
                    end
                end
                hfve_pkg::PH_COPY: begin
                    if (ends || crlf || cnt_full) begin
                        push0      = 1'b1;
                        res0.found = (r_count != '0);
                    end else begin
                        push0           = 1'b1;
                        res0.value_byte = r_in_byte;
                        res0.is_final   = 1'b0;
                        n_count         = CNT_W'(cnt_inc);
                        push1           = inc_full;
                    end
                end
                default: push0 = 1'b0;
            endcase
            if (r_in_end) begin
                n_count        = '0;
                win_ctrl.clear = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hfve_pkg::PH_SEARCH;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    hfve_matcher #(
        .KEY_MAX (KEY_MAX)
    ) u_matcher (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (win_ctrl),
        .i_key_lo  (r_key_lo),
        .i_key_hi  (r_key_hi),
        .i_key_len (r_key_len),
        .o_match   (match)
    );

    hfve_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_stat  (fifo_stat),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_value_byte = out_res.value_byte;
    assign o_is_final   = out_res.is_final;
    assign o_found      = out_res.found;

    `HFVE_ASSERT(a_second_is_final, push1 |-> (push0 && res1.is_final && !res0.is_final), "second result of a transfer must be the closing status")
    `HFVE_ASSERT(a_done_silent, (go && r_phase == hfve_pkg::PH_DONE) |-> !push0, "no results once the run is closed")
    `HFVE_ASSERT(a_queue_bound, fifo_stat.level <= hfve_pkg::OQ_LVL_W'(hfve_pkg::OQ_DEPTH), "result queue overflow")
    `HFVE_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!o_out_valid && o_in_ready), "queue and input register not empty after reset")

endmodule

FILE: bench/header_field_value_extractor_core_tb.sv
`timescale 1ns / 1ps
// testbench for header_field_value_extractor_core: directed and random header text
// checked against a scoreboard that predicts the value bytes and the status transfer
// depends on hfve_pkg and the core rtl; reads no files

module header_field_value_extractor_core_tb;
    import hfve_pkg::*;

    class field_value_tracker;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [4:0]  key_len;
        logic [8:0]  val_limit;
        logic [7:0]  window [16];
        int unsigned fill;
        t_phase      phase;
        int unsigned captured;
        t_result     pending_q [$];
        int unsigned errors;

        function new();
            key_lo    = '0;
            key_hi    = '0;
            key_len   = KEY_LEN_RST;
            val_limit = VAL_LIMIT_RST;
            errors    = 0;
            clear_run();
        endfunction

        function void clear_run();
            foreach (window[i]) window[i] = '0;
            fill     = 0;
            phase    = PH_SEARCH;
            captured = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [63:0] data);
            case (idx)
                CFG_KEY_LO:  key_lo = data;
                CFG_KEY_HI:  key_hi = data;
                CFG_KEY_LEN: key_len = data[4:0];
                CFG_VAL_LIM: val_limit = data[8:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] key_char(int unsigned i);
            logic [63:0] w;
            w = (i < 8) ? key_lo : key_hi;
            return w[8*(i%8) +: 8];
        endfunction

        function int unsigned key_span();
            if (key_len == 0) return 1;
            if (key_len > KEY_CHARS) return KEY_CHARS;
            return key_len;
        endfunction

        function int unsigned capture_cap();
            int unsigned v;
            v = (val_limit > VALUE_MAX_DEF) ? VALUE_MAX_DEF : val_limit;
            return (v == 0) ? 0 : v - 1;
        endfunction

        function logic [7:0] lower_ascii(logic [7:0] c);
            if (c >= 8'h41 && c <= 8'h5a) return c + 8'h20;
            return c;
        endfunction

        function bit key_in_window();
            int unsigned k;
            k = key_span();
            if (fill < k) return 0;
            for (int i = 0; i < k; i++) begin
                if (window[16 - k + i] != lower_ascii(key_char(i))) return 0;
            end
            return 1;
        endfunction

        function void expect_result(logic [7:0] b, logic fin, logic fnd);
            t_result r;
            r.value_byte = b;
            r.is_final   = fin;
            r.found      = fnd;
            pending_q.push_back(r);
        endfunction

        function void take_value_byte(logic [7:0] c, bit ends, bit crlf);
            if (ends || crlf || captured >= capture_cap()) begin
                expect_result(8'h00, 1'b1, captured > 0);
                phase = PH_DONE;
            end else begin
                expect_result(c, 1'b0, 1'b0);
                captured++;
                if (captured >= capture_cap()) begin
                    expect_result(8'h00, 1'b1, 1'b1);
                    phase = PH_DONE;
                end
            end
        endfunction

        function void note_byte(logic [7:0] c, logic eot);
            bit ends;
            bit crlf;
            ends = eot || (c == CH_NUL);
            crlf = (c == CH_CR) || (c == CH_LF);
            case (phase)
                PH_SEARCH: begin
                    if (ends) begin
                        expect_result(8'h00, 1'b1, 1'b0);
                        phase = PH_DONE;
                    end else begin
                        for (int i = 0; i < 15; i++) window[i] = window[i+1];
                        window[15] = lower_ascii(c);
                        if (fill < 16) fill++;
                        if (key_in_window()) phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (ends || !(c == CH_SPACE || c == CH_TAB)) begin
                        if (ends || crlf || capture_cap() == 0) begin
                            expect_result(8'h00, 1'b1, 1'b0);
                            phase = PH_DONE;
                        end else begin
                            phase = PH_COPY;
                            take_value_byte(c, ends, crlf);
                        end
                    end
                end
                PH_COPY: take_value_byte(c, ends, crlf);
                default: ;
            endcase
            if (eot) clear_run();
        endfunction

        function int unsigned waiting();
            return pending_q.size();
        endfunction

        function void flag(string what, t_result want, logic [7:0] vb, logic fin, logic fnd);
            errors++;
            if (errors <= 10) begin
                $display("mismatch (%s) at %0t: expected byte %02h final %0b found %0b,",
                         what, $realtime, want.value_byte, want.is_final, want.found,
                         " got byte %02h final %0b found %0b", vb, fin, fnd);
            end
        endfunction

        function void check_result(logic [7:0] vb, logic fin, logic fnd);
            t_result want;
            if (pending_q.size() == 0) begin
                want = '0;
                flag("no transfer expected", want, vb, fin, fnd);
                return;
            end
            want = pending_q.pop_front();
            if (vb !== want.value_byte || fin !== want.is_final || fnd !== want.found) begin
                flag("wrong field", want, vb, fin, fnd);
            end
        endfunction
    endclass

    localparam logic [4:0] LEN_PICKS [8]   = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd2, 5'd8, 5'd12};
    localparam logic [8:0] LIMIT_PICKS [8] = '{9'd256, 9'd3, 9'd1, 9'd0, 9'd511, 9'd2, 9'd12, 9'd5};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_text_byte   = 8'h00;
    logic        i_end_of_text = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [7:0]  o_value_byte;
    logic        o_is_final;
    logic        o_found;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = CFG_KEY_LO;
    logic [63:0] i_cfg_data    = 64'h0;

    field_value_tracker tracker = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned items_sent    = 0;
    int unsigned setting_no    = 0;
    bit          stall_request = 1'b0;

    header_field_value_extractor_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value_byte  (o_value_byte),
        .o_is_final    (o_is_final),
        .o_found       (o_found),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver side, with a long hold-off on request
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                stall_left    = 120;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_result(o_value_byte, o_is_final, o_found);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_byte(b, eot);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_register(idx, data);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [63:0] klo, input logic [63:0] khi,
                                  input logic [4:0] klen, input logic [8:0] vlim);
        write_register(CFG_KEY_LO, klo);
        write_register(CFG_KEY_HI, khi);
        write_register(CFG_KEY_LEN, {59'h0, klen});
        write_register(CFG_VAL_LIM, {55'h0, vlim});
        i_cfg_valid <= 1'b0;
    endtask

    // no transfer outstanding, then let the pipeline empty
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tracker.waiting() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [63:0] random_key_word();
        logic [63:0] w;
        logic [7:0]  c;
        w = '0;
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(7))
                0:       c = 8'($urandom_range(1, 255));
                1:       c = 8'($urandom_range(8'h2d, 8'h3a));
                2, 3, 4: c = 8'($urandom_range(8'h41, 8'h5a));
                default: c = 8'($urandom_range(8'h61, 8'h7a));
            endcase
            w[8*i +: 8] = c;
        end
        return w;
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        if (((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a))
            && $urandom_range(1) == 1) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] b;
        if ($urandom_range(4) == 0) begin
            b = 8'($urandom_range(1, 255));
        end else begin
            b = 8'($urandom_range(8'h21, 8'h7e));
        end
        if (b == CH_CR || b == CH_LF) b = 8'h2e;
        return b;
    endfunction

    function automatic int unsigned value_length();
        int unsigned cap;
        cap = tracker.capture_cap();
        if (cap <= 12) return $urandom_range(0, cap + 2);
        if ($urandom_range(15) == 0) return cap + 1;
        return $urandom_range(0, 8);
    endfunction

    task automatic send_noise_line();
        int unsigned len;
        int unsigned r;
        logic [7:0]  b;
        len = $urandom_range(0, 6);
        repeat (len) begin
            r = $urandom_range(39);
            if (r == 0) begin
                b = CH_NUL;
            end else if (r < 10) begin
                b = 8'($urandom_range(1, 255));
            end else begin
                b = 8'($urandom_range(8'h20, 8'h7e));
            end
            send_byte(b, 1'b0);
        end
        if ($urandom_range(1) == 1) send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
    endtask

    // one header block: optional noise, the key line (sometimes broken), terminator
    task automatic send_run();
        int unsigned k;
        int unsigned cut;
        int unsigned len;
        k = tracker.key_span();
        repeat ($urandom_range(0, 2)) send_noise_line();
        if ($urandom_range(9) < 8) begin
            cut = ($urandom_range(7) == 0) ? $urandom_range(0, k - 1) : k;
            for (int i = 0; i < cut; i++) send_byte(flip_case(tracker.key_char(i)), 1'b0);
            repeat ($urandom_range(0, 3)) begin
                send_byte(($urandom_range(1) == 1) ? CH_SPACE : CH_TAB, 1'b0);
            end
            len = value_length();
            repeat (len) send_byte(value_char(), 1'b0);
            case ($urandom_range(9))
                0: ;
                1: send_byte(CH_NUL, 1'b0);
                2: send_byte(CH_LF, 1'b0);
                default: begin
                    send_byte(CH_CR, 1'b0);
                    send_byte(CH_LF, 1'b0);
                end
            endcase
            if ($urandom_range(1) == 1) send_noise_line();
        end
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic pick_settings();
        logic [4:0] klen;
        logic [8:0] vlim;
        if (setting_no < 8) begin
            klen = LEN_PICKS[setting_no];
            vlim = LIMIT_PICKS[setting_no];
        end else begin
            klen = ($urandom_range(3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(1, 6));
            vlim = ($urandom_range(3) == 0) ? 9'($urandom_range(0, 511))
                                            : 9'($urandom_range(0, 20));
        end
        setting_no++;
        apply_settings(random_key_word(), random_key_word(), klen, vlim);
    endtask

    task automatic run_phase(input int unsigned snd, input int unsigned rcv,
                             input int unsigned upto);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        while (items_sent < upto) begin
            wait_drained();
            pick_settings();
            repeat (3) send_run();
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset key never matches
        send_byte(8'h41, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();

        // key "K:", buffer fills after two bytes
        apply_settings(64'h3a4b, 64'h0, 5'd2, 9'd3);
        send_byte(8'h6b, 1'b0);
        send_byte(8'h3a, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h79, 1'b0);
        send_byte(8'h7a, 1'b0);
        send_byte(8'h00, 1'b1);

        // zero byte straight after the key
        send_byte(8'h4b, 1'b0);
        send_byte(8'h3a, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(8'h55, 1'b1);
        wait_drained();

        // limit lowered while a value is being captured
        apply_settings(64'h3a4b, 64'h0, 5'd2, 9'd256);
        send_byte(8'h6b, 1'b0);
        send_byte(8'h3a, 1'b0);
        send_byte(8'h61, 1'b0);
        wait_drained();
        write_register(CFG_VAL_LIM, 64'd2);
        i_cfg_valid <= 1'b0;
        send_byte(8'h62, 1'b0);
        send_byte(8'h00, 1'b1);

        run_phase(30, 78, 460);
        run_phase(78, 30, 900);

        // long receiver hold-off while the sender keeps offering bytes
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_drained();
        pick_settings();
        stall_request = 1'b1;
        repeat (8) send_run();

        run_phase(0, 0, 1320);

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (tracker.errors == 0 && tracker.waiting() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
